// File: src/best_quality_window_finder_defines.svh
// Assertion macros used by the checker file.
`ifndef BEST_QUALITY_WINDOW_FINDER_DEFINES_SVH
`define BEST_QUALITY_WINDOW_FINDER_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define BQW_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("bqw assertion failed");

// Next-cycle implication, disabled while reset is high.
`define BQW_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("bqw assertion failed");

`endif

// File: src/bqw_pkg.sv
package bqw_pkg;

   localparam int MAX_SCORE   = 93;
   localparam int SCORE_W     = 7;
   localparam int CHAR_W      = 8;
   localparam int CSR_W       = 9;
   localparam int POS_W       = 16;
   localparam int ENTRY_W     = 32;
   localparam int PHRED_BASE  = 33;
   localparam int DEFAULT_K   = 31;

   localparam logic [63:0] ONE_Q62   = 64'h4000_0000_0000_0000;
   localparam logic [63:0] TWO_Q62   = 64'h8000_0000_0000_0000;
   localparam logic [63:0] TENTH_Q62 = ONE_Q62 / 10;

   typedef logic [SCORE_W-1:0] score_type;
   typedef logic [MAX_SCORE:0][ENTRY_W-1:0] cost_table_type;

   // (a * b) >> 62, truncated to 64 bits
   function automatic logic [63:0] mul_q62(input logic [63:0] a, input logic [63:0] b);
      logic [127:0] prod;
      prod = {64'd0, a} * {64'd0, b};
      return prod[125:62];
   endfunction

   function automatic logic [63:0] pow10_q62(input logic [63:0] c);
      logic [63:0] r;
      r = c;
      for (int i = 1; i < 10; i++) begin
         r = mul_q62(r, c);
      end
      return r;
   endfunction

   // Cost of score q: -log2(1 - 10^(-q/10)) in unsigned 8.24, score 0 saturated.
   function automatic cost_table_type build_cost_table();
      cost_table_type tbl;
      logic [63:0] lo;
      logic [63:0] hi;
      logic [63:0] mid;
      logic [63:0] c;
      logic [63:0] p;
      logic [63:0] y;
      logic [63:0] frac;
      logic [63:0] e;
      logic [63:0] cq40;
      lo = 64'd0;
      hi = ONE_Q62;
      for (int it = 0; it < 64; it++) begin
         if (hi - lo > 64'd1) begin
            mid = lo + ((hi - lo) >> 1);
            if (pow10_q62(mid) <= TENTH_Q62) begin
               lo = mid;
            end else begin
               hi = mid;
            end
         end
      end
      c = lo;
      tbl[0] = {ENTRY_W{1'b1}};
      p = ONE_Q62;
      for (int q = 1; q <= MAX_SCORE; q++) begin
         p = mul_q62(p, c);
         y = ONE_Q62 - p;
         e = 64'd0;
         frac = 64'd0;
         for (int s = 0; s < 64; s++) begin
            if (y < ONE_Q62) begin
               y = y << 1;
               e = e + 64'd1;
            end
         end
         for (int i = 0; i < 40; i++) begin
            y = mul_q62(y, y);
            frac = frac << 1;
            if (y >= TWO_Q62) begin
               y = y >> 1;
               frac[0] = 1'b1;
            end
         end
         cq40 = (e << 40) - frac;
         tbl[q] = ENTRY_W'((cq40 + 64'h8000) >> 16);
      end
      return tbl;
   endfunction

   localparam cost_table_type COST_TABLE = build_cost_table();

endpackage

// File: src/best_quality_window_finder.sv
// Channel  Direction  tdata                tuser       tlast
// req      in         [7:0] qual_char      -           last_char
// rsp      out        [15:0] best_start    too_short   -
// csr      in         wr_data[8:0] window_len (write on csr_wr_en)
//
// One quality beat per cycle: cost lookup, window add/subtract and best compare
// all close in the cycle of acceptance; the score line shifts one cell per beat.
// The result lands in the rsp register at the edge that takes the last beat.
// reset (synchronous) clears counts, sums and the result valid flag; the score
// line has no clearing pass since a cell is read only after this read filled it.
// A stalled result blocks only a new last beat; other beats keep flowing.
module best_quality_window_finder #(
   parameter int MAX_WINDOW   = 256,
   parameter int MAX_READ_LEN = 65536
) (
   input  logic                           clock,
   input  logic                           reset,
   // req_tdata: [7:0] qual_char
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [bqw_pkg::CHAR_W-1:0]     req_tdata,
   input  logic                           req_tlast,
   // rsp_tdata: [15:0] best_start
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [bqw_pkg::POS_W-1:0]      rsp_tdata,
   // rsp_tuser: [0] too_short
   output logic                           rsp_tuser,
   input  logic                           csr_wr_en,
   input  logic [bqw_pkg::CSR_W-1:0]      csr_wr_data
);
   import bqw_pkg::*;

   localparam int KW     = $clog2(MAX_WINDOW + 1);
   localparam int CNT_W  = $clog2(MAX_READ_LEN + 1);
   localparam int COST_W = ENTRY_W + $clog2(MAX_WINDOW);

   // configuration and latched window length
   logic [CSR_W-1:0]  window_len_ff;
   logic [CSR_W-1:0]  window_len_in;
   logic [KW-1:0]     k_ff;
   logic [KW-1:0]     k_in;
   logic [KW-1:0]     k_csr;
   logic [KW-1:0]     k_eff;

   // read state
   logic [CNT_W-1:0]  char_count_ff;
   logic [CNT_W-1:0]  char_count_in;
   logic [COST_W-1:0] window_cost_ff;
   logic [COST_W-1:0] window_cost_in;
   logic [COST_W-1:0] best_cost_ff;
   logic [COST_W-1:0] best_cost_in;
   logic [POS_W-1:0]  best_pos_ff;
   logic [POS_W-1:0]  best_pos_in;

   // result register
   logic              rsp_valid_ff;
   logic              rsp_valid_in;
   logic [POS_W-1:0]  rsp_start_ff;
   logic [POS_W-1:0]  rsp_start_in;
   logic              rsp_short_ff;
   logic              rsp_short_in;

   // datapath
   logic              req_accept;
   logic              first_beat;
   logic              in_range;
   logic              shift_en;
   score_type         new_score;
   score_type         old_score;
   score_type         cell_score [MAX_WINDOW];
   logic [COST_W-1:0] sum_add;
   logic [COST_W-1:0] sum_next;
   logic [CNT_W-1:0]  n_plus;
   logic [CNT_W-1:0]  start_full;
   logic [CNT_W-1:0]  count_after;
   logic [POS_W-1:0]  pos_after;
   logic [COST_W-1:0] best_after;
   logic [COST_W-1:0] cost_after;
   logic              take_best;

   // Block only a last beat while the result register is full and stalled.
   assign req_tready = !rsp_valid_ff || rsp_tready || !req_tlast;
   assign req_accept = req_tvalid && req_tready;

   always_comb begin
      // clamp window_len into 1..MAX_WINDOW
      if (window_len_ff == '0) begin
         k_csr = KW'(1);
      end else if (window_len_ff > MAX_WINDOW) begin
         k_csr = KW'(MAX_WINDOW);
      end else begin
         k_csr = KW'(window_len_ff);
      end
      first_beat = (char_count_ff == '0);
      k_eff      = first_beat ? k_csr : k_ff;
      in_range   = (char_count_ff < MAX_READ_LEN);
      shift_en   = req_accept && in_range;

      // phred score, clamped
      if (req_tdata < PHRED_BASE) begin
         new_score = '0;
      end else if (req_tdata - CHAR_W'(PHRED_BASE) > MAX_SCORE) begin
         new_score = SCORE_W'(MAX_SCORE);
      end else begin
         new_score = SCORE_W'(req_tdata - CHAR_W'(PHRED_BASE));
      end
      old_score = (cell_score[MAX_WINDOW-1] > MAX_SCORE) ? SCORE_W'(MAX_SCORE)
                                                         : cell_score[MAX_WINDOW-1];

      // slide the window: add entering cost, drop the one that leaves
      sum_add = window_cost_ff + COST_W'(COST_TABLE[new_score]);
      if (char_count_ff >= k_eff) begin
         sum_next = sum_add - COST_W'(COST_TABLE[old_score]);
      end else begin
         sum_next = sum_add;
      end
      n_plus     = char_count_ff + CNT_W'(1);
      start_full = n_plus - CNT_W'(k_eff);
      take_best  = in_range && (n_plus >= k_eff) &&
                   ((start_full == '0) || (sum_next < best_cost_ff));

      count_after = in_range ? n_plus : char_count_ff;
      cost_after  = in_range ? sum_next : window_cost_ff;
      pos_after   = take_best ? POS_W'(start_full) : best_pos_ff;
      best_after  = take_best ? sum_next : best_cost_ff;

      // defaults: hold
      window_len_in  = csr_wr_en ? csr_wr_data : window_len_ff;
      k_in           = (req_accept && first_beat) ? k_csr : k_ff;
      char_count_in  = char_count_ff;
      window_cost_in = window_cost_ff;
      best_cost_in   = best_cost_ff;
      best_pos_in    = best_pos_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_tready;
      rsp_start_in   = rsp_start_ff;
      rsp_short_in   = rsp_short_ff;

      if (req_accept) begin
         if (req_tlast) begin
            // emit and return read state to reset values
            rsp_valid_in   = 1'b1;
            rsp_short_in   = (count_after < k_eff);
            rsp_start_in   = (count_after < k_eff) ? '0 : pos_after;
            char_count_in  = '0;
            window_cost_in = '0;
            best_cost_in   = '1;
            best_pos_in    = '0;
         end else begin
            char_count_in  = count_after;
            window_cost_in = cost_after;
            best_cost_in   = best_after;
            best_pos_in    = pos_after;
         end
      end
   end

   // score line: insertion cell picked by k, oldest score read at the end
   for (genvar i = 0; i < MAX_WINDOW; i++) begin : g_cell
      bqw_cell #(
         .INDEX      (i),
         .MAX_WINDOW (MAX_WINDOW),
         .KW         (KW)
      ) u_cell (
         .clock      (clock),
         .shift_en   (shift_en),
         .k          (k_eff),
         .new_score  (new_score),
         .prev_score ((i == 0) ? new_score : cell_score[(i == 0) ? 0 : i-1]),
         .score_out  (cell_score[i])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_len_ff  <= CSR_W'(DEFAULT_K);
         k_ff           <= KW'(DEFAULT_K);
         char_count_ff  <= '0;
         window_cost_ff <= '0;
         best_cost_ff   <= '1;
         best_pos_ff    <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         window_len_ff  <= window_len_in;
         k_ff           <= k_in;
         char_count_ff  <= char_count_in;
         window_cost_ff <= window_cost_in;
         best_cost_ff   <= best_cost_in;
         best_pos_ff    <= best_pos_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_start_ff <= rsp_start_in;
      rsp_short_ff <= rsp_short_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_start_ff;
   assign rsp_tuser  = rsp_short_ff;

endmodule

// File: src/bqw_cell.sv
module bqw_cell #(
   parameter int INDEX      = 0,
   parameter int MAX_WINDOW = 256,
   parameter int KW         = 9
) (
   input  logic                    clock,
   input  logic                    shift_en,
   input  logic [KW-1:0]           k,
   input  bqw_pkg::score_type      new_score,
   input  bqw_pkg::score_type      prev_score,
   output bqw_pkg::score_type      score_out
);
   import bqw_pkg::*;

   // This cell is the insertion point when the window is this far from the end.
   localparam logic [KW-1:0] TAP_K = KW'(MAX_WINDOW - INDEX);

   score_type score_ff;
   score_type score_in;

   always_comb begin
      score_in = (k == TAP_K) ? new_score : prev_score;
   end

   always_ff @(posedge clock) begin
      if (shift_en) begin
         score_ff <= score_in;
      end
   end

   assign score_out = score_ff;

endmodule

// File: src/bqw_checker.sv
`include "best_quality_window_finder_defines.svh"

module bqw_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_tvalid,
   input logic                           req_tready,
   input logic                           req_tlast,
   input logic                           rsp_tvalid,
   input logic                           rsp_tready,
   input logic [bqw_pkg::POS_W-1:0]      rsp_tdata,
   input logic                           rsp_tuser
);

   // hold a stalled result beat
   `BQW_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable({rsp_tdata, rsp_tuser}))
   // a short read always reports start zero
   `BQW_ASSERT_NOW(a_short_zero, clock, reset, rsp_tvalid && rsp_tuser, rsp_tdata == '0)
   // a result appears only after a last beat was taken
   `BQW_ASSERT_NOW(a_rsp_cause, clock, reset, $rose(rsp_tvalid), $past(req_tvalid && req_tready && req_tlast))
   // a stalled result blocks a new last beat
   `BQW_ASSERT_NOW(a_last_block, clock, reset, rsp_tvalid && !rsp_tready && req_tlast, !req_tready)

endmodule

bind best_quality_window_finder bqw_checker u_bqw_checker (.*);
